@@ src/rbb_pkg.sv @@
// Package for the RGB box blur core: widths, register indexes, the channel maximum
// and the command/status structs. No dependencies.
package rbb_pkg;
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int MAX_KERNEL = 7;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = 11;
    localparam int KROW_W  = $clog2(MAX_KERNEL);
    localparam int ADDR_W  = $clog2(MAX_KERNEL * MAX_WIDTH);
    localparam int SUM_W   = 14;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_KERNEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    localparam logic [7:0] CHAN_MAX = 8'd255;

    typedef struct packed {
        logic              wr;
        logic              start;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [KROW_W-1:0] krow;
        logic [2:0]        k;
        logic [23:0]       pix;
    } t_cmd;

    typedef struct packed {
        logic done;
    } t_stat;
endpackage

@@ src/rbb_if.sv @@
// Valid/ready stream interfaces for pixels in and blurred pixels out.
// Depends on rbb_pkg.
interface rbb_in_if import rbb_pkg::*; ();
    logic       valid;
    logic       ready;
    logic       frame_start;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    modport source(output valid, frame_start, in_red, in_green, in_blue, input ready);
    modport sink(input valid, frame_start, in_red, in_green, in_blue, output ready);
endinterface

interface rbb_out_if import rbb_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [10:0] out_col;
    logic [10:0] out_row;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    modport source(output valid, out_col, out_row, out_red, out_green, out_blue,
                   input ready);
    modport sink(input valid, out_col, out_row, out_red, out_green, out_blue,
                 output ready);
endinterface

@@ src/rgb_box_blur_core.sv @@
// Top level of the RGB box blur core: ties controller and datapath together.
// Depends on rbb_pkg, rbb_in_if, rbb_out_if, rbb_ctrl and rbb_datapath.
//
// Usage: pixels arrive in raster order on the input channel; frame_start
// on a transfer puts it at column 0, row 0. Every pixel is stored in a
// seven-row line memory. A pixel that completes a k-by-k window around a
// centre at least k/2 from every edge starts a job: the window is read one
// pixel a cycle from the line memory port, then the three channel sums are
// divided by k*k with a shared-step restoring divider. When the division
// ends the result is offered and the block is idle again; pixels that start
// no window are taken one per cycle while the block is idle. The result
// waits in an output register and is offered on the output channel; while
// it waits untaken the block takes no further pixel. The user must write
// configuration through the write port only while idle; the block itself
// does not enforce this. Reset clears the coordinates and the registers to
// kernel 3, 640 by 480; the line memory is not cleared.
module rgb_box_blur_core import rbb_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    rbb_in_if.sink               i_pix,
    rbb_out_if.source            o_res
);
    t_cmd  cmd;
    t_stat stat;

    rbb_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_pix.valid), .o_in_ready(i_pix.ready),
        .i_frame_start(i_pix.frame_start),
        .i_pix({i_pix.in_blue, i_pix.in_green, i_pix.in_red}),
        .o_cmd(cmd), .i_stat(stat),
        .o_out_valid(o_res.valid), .i_out_ready(o_res.ready)
    );

    // Writes of pixels that start no window go through the same port.
    rbb_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(cmd), .o_stat(stat),
        .o_col(o_res.out_col), .o_row(o_res.out_row),
        .o_red(o_res.out_red), .o_green(o_res.out_green), .o_blue(o_res.out_blue)
    );
endmodule

@@ src/rbb_datapath.sv @@
// Datapath: line store memory, window accumulation and division by k*k.
// Depends on rbb_pkg.
module rbb_datapath import rbb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    output logic [10:0] o_col,
    output logic [10:0] o_row,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;

    logic [23:0] r_mem [MAX_KERNEL*MAX_WIDTH];
    logic [23:0] r_rdata;
    logic [1:0]  r_st;
    logic [2:0]  r_k, r_x, r_y;
    logic [KROW_W-1:0] r_ym;
    logic [COL_W-1:0] r_c0;
    logic [COL_W-1:0] r_cc;
    logic [ROW_W-1:0] r_rc;
    logic        r_pend;
    logic        r_last;
    logic [SUM_W-1:0] r_sr, r_sg, r_sb;
    logic [5:0]  r_area;
    logic [SUM_W-1:0] r_q [3];
    logic [SUM_W-1:0] r_rem [3];
    logic [3:0]  r_dcnt;
    logic [7:0]  r_red, r_green, r_blue;

    logic [COL_W-1:0] xcol;
    logic [ADDR_W-1:0] raddr, waddr;
    logic [KROW_W:0]   ybase;

    // The line store row of the window's top row: the current pixel's store row
    // minus k-1, modulo the number of stored rows.
    assign ybase = (i_cmd.krow >= KROW_W'(i_cmd.k - 3'd1))
                 ? {1'b0, i_cmd.krow - KROW_W'(i_cmd.k - 3'd1)}
                 : (KROW_W+1)'(i_cmd.krow) + (KROW_W+1)'(MAX_KERNEL)
                   - (KROW_W+1)'(i_cmd.k - 3'd1);
    assign xcol  = r_c0 + COL_W'(r_x);
    assign waddr = {i_cmd.krow, i_cmd.col};
    assign raddr = {r_ym, xcol};

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem[waddr] <= i_cmd.pix;
        end
        r_rdata <= r_mem[raddr];
    end

    function automatic logic [7:0] clamp(input logic [SUM_W-1:0] q);
        clamp = (q > SUM_W'(CHAN_MAX)) ? CHAN_MAX : q[7:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_pend <= 1'b0;
        end else begin
            case (r_st)
                S_IDLE: begin
                    r_pend <= 1'b0;
                    if (i_cmd.start) begin
                        r_k  <= i_cmd.k;
                        r_c0 <= i_cmd.col - COL_W'(i_cmd.k - 3'd1);
                        r_ym <= ybase[KROW_W-1:0];
                        r_cc <= i_cmd.col - COL_W'((i_cmd.k - 3'd1) >> 1);
                        r_rc <= i_cmd.row - ROW_W'((i_cmd.k - 3'd1) >> 1);
                        r_area <= 6'(i_cmd.k) * 6'(i_cmd.k);
                        r_x <= 3'd0;
                        r_y <= 3'd0;
                        r_sr <= '0; r_sg <= '0; r_sb <= '0;
                        r_last <= 1'b0;
                        r_st <= S_RD;
                    end
                end
                S_RD: begin
                    // Read issued for (r_x,r_y); the data lands in r_rdata on the next cycle.
                    if (r_pend) begin
                        r_sr <= r_sr + SUM_W'(r_rdata[7:0]);
                        r_sg <= r_sg + SUM_W'(r_rdata[15:8]);
                        r_sb <= r_sb + SUM_W'(r_rdata[23:16]);
                    end
                    if (r_last) begin
                        r_pend <= 1'b0;
                        r_st   <= S_DIV;
                        r_dcnt <= 4'd0;
                        r_q[0] <= r_sr + SUM_W'(r_rdata[7:0]);
                        r_q[1] <= r_sg + SUM_W'(r_rdata[15:8]);
                        r_q[2] <= r_sb + SUM_W'(r_rdata[23:16]);
                        for (int i = 0; i < 3; i++) r_rem[i] <= '0;
                    end else begin
                        r_pend <= 1'b1;
                        if (r_x == r_k - 3'd1) begin
                            r_x <= 3'd0;
                            r_y <= r_y + 3'd1;
                            r_ym <= (r_ym == KROW_W'(MAX_KERNEL - 1)) ? '0
                                                                     : r_ym + KROW_W'(1);
                            if (r_y == r_k - 3'd1) r_last <= 1'b1;
                        end else begin
                            r_x <= r_x + 3'd1;
                        end
                    end
                end
                S_DIV: begin
                    // Restoring division, one quotient bit per cycle per channel.
                    for (int i = 0; i < 3; i++) begin
                        logic [SUM_W:0] t;
                        t = {r_rem[i], r_q[i][SUM_W-1]};
                        if (t >= (SUM_W+1)'(r_area)) begin
                            r_rem[i] <= SUM_W'(t - (SUM_W+1)'(r_area));
                            r_q[i]   <= {r_q[i][SUM_W-2:0], 1'b1};
                        end else begin
                            r_rem[i] <= t[SUM_W-1:0];
                            r_q[i]   <= {r_q[i][SUM_W-2:0], 1'b0};
                        end
                    end
                    r_dcnt <= r_dcnt + 4'd1;
                    if (r_dcnt == 4'(SUM_W)) begin
                        r_red   <= clamp(r_q[0]);
                        r_green <= clamp(r_q[1]);
                        r_blue  <= clamp(r_q[2]);
                        r_st    <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    // r_last marks the cycle in which the final word arrives; it is summed straight
    // into r_q in the transition, while r_pend keeps the first read cycle out of the sums.
    assign o_stat.done = (r_st == S_DIV) && (r_dcnt == 4'(SUM_W));
    assign o_col   = r_cc;
    assign o_row   = r_rc;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;
endmodule

@@ src/rbb_ctrl.sv @@
// Controller: configuration registers, pixel coordinates, handshakes.
// Depends on rbb_pkg.
module rbb_ctrl import rbb_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_frame_start,
    input  logic [23:0]          i_pix,
    output t_cmd                 o_cmd,
    input  t_stat                i_stat,
    output logic                 o_out_valid,
    input  logic                 i_out_ready
);
    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_WORK = 2'd1;

    logic [1:0]  r_state;
    logic [2:0]  r_kreg;
    logic [11:0] r_wreg, r_hreg;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [KROW_W-1:0] r_rmod;
    logic        r_ovalid;

    logic [2:0]  k;
    logic [12:0] w, h;
    logic [COL_W-1:0] c;
    logic [ROW_W-1:0] r;
    logic [KROW_W-1:0] rm;
    logic [12:0] c1, r1;
    logic        acc, emit;

    always_comb begin
        k = r_kreg | 3'd1;
        w = (r_wreg == 12'd0) ? 13'd1 : (13'(r_wreg) > 13'(MAX_WIDTH) ? 13'(MAX_WIDTH) : 13'(r_wreg));
        h = (r_hreg == 12'd0) ? 13'd1 : (13'(r_hreg) > 13'(MAX_HEIGHT) ? 13'(MAX_HEIGHT) : 13'(r_hreg));
        c = i_frame_start ? '0 : ((13'(r_col) >= w) ? '0 : r_col);
        r = i_frame_start ? '0 : ((13'(r_row) >= h) ? '0 : r_row);
        // Line store row of the current pixel, kept in step with the row count.
        rm = (i_frame_start || (13'(r_row) >= h)) ? '0 : r_rmod;
        c1 = 13'(c) + 13'd1;
        r1 = 13'(r) + 13'd1;
    end

    assign o_in_ready = i_rst_n && (r_state == C_IDLE) && !(r_ovalid && !i_out_ready);
    assign acc  = i_in_valid && o_in_ready;
    assign emit = (13'(c) >= 13'(k - 3'd1)) && (13'(r) >= 13'(k - 3'd1));

    // Every accepted pixel is written; one that completes a window also starts a job.
    assign o_cmd.wr    = acc;
    assign o_cmd.start = acc && emit;
    assign o_cmd.col   = c;
    assign o_cmd.row   = r;
    assign o_cmd.krow  = rm;
    assign o_cmd.k     = k;
    assign o_cmd.pix   = i_pix;
    assign o_out_valid = r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_kreg  <= 3'd3;
            r_wreg  <= 12'd640;
            r_hreg  <= 12'd480;
            r_col   <= '0;
            r_row   <= '0;
            r_rmod  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_KERNEL: r_kreg <= i_cfg_data[2:0];
                    REG_WIDTH:  r_wreg <= i_cfg_data;
                    REG_HEIGHT: r_hreg <= i_cfg_data;
                    default: ;
                endcase
            end
            if (acc) begin
                if (c1 >= w) begin
                    r_col <= '0;
                    if (r1 >= h) begin
                        r_row  <= '0;
                        r_rmod <= '0;
                    end else begin
                        r_row  <= r1[ROW_W-1:0];
                        r_rmod <= (rm == KROW_W'(MAX_KERNEL - 1)) ? '0 : rm + KROW_W'(1);
                    end
                end else begin
                    r_col  <= c1[COL_W-1:0];
                    r_row  <= r;
                    r_rmod <= rm;
                end
            end
            if (i_stat.done) r_ovalid <= 1'b1;
            else if (r_ovalid && i_out_ready) r_ovalid <= 1'b0;
            case (r_state)
                C_IDLE: if (o_cmd.start) r_state <= C_WORK;
                C_WORK: if (i_stat.done) r_state <= C_IDLE;
                default: r_state <= C_IDLE;
            endcase
        end
    end
endmodule
